FILE: design/pnsd_pkg.sv
// ----------------------------------------------------------------------------
// Packed name string decoder package
// Shared encoding codes, register indexes, reset values and the result types
// exchanged between the decode core and the output buffer.
// ----------------------------------------------------------------------------
package pnsd_pkg;

	localparam logic [2:0] ENC_UTF8     = 3'd0;
	localparam logic [2:0] ENC_MIXED    = 3'd2;
	localparam logic [2:0] ENC_FIRST_UP = 3'd3;
	localparam logic [2:0] ENC_BAR_UP   = 3'd4;

	localparam logic CFG_SPECIAL_ONE = 1'b0;
	localparam logic CFG_SPECIAL_TWO = 1'b1;

	localparam logic [7:0] SPECIAL_ONE_RST = 8'd46;
	localparam logic [7:0] SPECIAL_TWO_RST = 8'd95;

	localparam int RES_MAX = 3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_present;
		logic       end_of_string;
		logic       error;
	} pnsd_res_t;

	typedef struct packed {
		logic                         load;
		logic [1:0]                   count;
		pnsd_res_t [RES_MAX-1:0]      res;
	} pnsd_bundle_t;

endpackage

FILE: design/packed_name_string_decoder_top.sv
// ----------------------------------------------------------------------------
// Packed name string decoder
// Decodes the payload bytes of a packed name string into characters.
// ----------------------------------------------------------------------------
// One byte is taken per item and decoded in a single registered pass; its
// results, at most three, then leave through a three-slot output buffer at one
// per cycle while the result side does not stall. A byte holds the result
// channel until its results are handed out; a byte with no results does not
// hold it. The next byte is decoded in the cycle the buffer hands out its last
// waiting result, so the two sides overlap without a bubble.
module packed_name_string_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic [2:0] encoding,
	input  logic       last_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] char_code,
	output logic       char_present,
	output logic       end_of_string,
	output logic       error,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import pnsd_pkg::*;

	pnsd_bundle_t bundle;
	pnsd_res_t    head;
	logic         can_load;

	pnsd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.data_byte  (data_byte),
		.encoding   (encoding),
		.last_byte  (last_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.can_load   (can_load),
		.bundle     (bundle)
	);

	pnsd_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.bundle     (bundle),
		.can_load   (can_load),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.head       (head)
	);

	assign char_code     = head.char_code;
	assign char_present  = head.char_present;
	assign end_of_string = head.end_of_string;
	assign error         = head.error;

endmodule

FILE: design/pnsd_core.sv
// ----------------------------------------------------------------------------
// Packed name string decoder core
// Holds the input item register, the per-string decode state and the special
// character registers, and turns one item into up to three results.
// ----------------------------------------------------------------------------
module pnsd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [7:0]            data_byte,
	input  logic [2:0]            encoding,
	input  logic                  last_byte,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  can_load,
	output pnsd_pkg::pnsd_bundle_t bundle
);
	import pnsd_pkg::*;

	typedef struct packed {
		logic [4:0] bit_buffer;
		logic [2:0] bit_count;
		logic [2:0] mode;
		logic       strip;
		logic       at_start;
		logic [5:0] held;
		logic       held_v;
		logic       bar;
		logic       fcn;
		logic       err;
	} pnsd_state_t;

	typedef struct packed {
		logic      emit;
		pnsd_res_t res;
		logic      fail;
		logic      fcn;
		logic      bar;
	} pnsd_rel_t;

	localparam pnsd_state_t STATE_CLEAR = '{
		bit_buffer: 5'd0, bit_count: 3'd0, mode: ENC_UTF8, strip: 1'b0,
		at_start: 1'b1, held: 6'd0, held_v: 1'b0, bar: 1'b0, fcn: 1'b1,
		err: 1'b0
	};

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic logic [7:0] five_char(input logic [4:0] v);
		logic [7:0] c;
		if (v < 5'd26) begin
			c = "a" + {3'd0, v};
		end else if (v == 5'd26) begin
			c = ".";
		end else if (v == 5'd27) begin
			c = "_";
		end else if (v == 5'd28) begin
			c = "$";
		end else begin
			c = "|";
		end
		return c;
	endfunction

	function automatic logic [7:0] six_char(input logic [5:0] v, input logic [7:0] sp1,
			input logic [7:0] sp2);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = "a" + {2'd0, v};
		end else if (v < 6'd52) begin
			c = "A" + ({2'd0, v} - 8'd26);
		end else if (v < 6'd62) begin
			c = "0" + ({2'd0, v} - 8'd52);
		end else if (v == 6'd62) begin
			c = sp1;
		end else begin
			c = sp2;
		end
		return c;
	endfunction

	function automatic pnsd_rel_t release_code(input logic [5:0] code, input logic [2:0] mode,
			input logic fcn, input logic bar, input logic [7:0] sp1, input logic [7:0] sp2);
		pnsd_rel_t r;
		logic [7:0] c;
		r = '0;
		r.fcn = fcn;
		r.bar = bar;
		c = five_char(code[4:0]);
		if (mode == ENC_MIXED) begin
			r.emit = 1'b1;
			r.res.char_code = six_char(code, sp1, sp2);
			r.res.char_present = 1'b1;
		end else if (code[4:0] >= 5'd30) begin
			r.emit = 1'b1;
			r.res.error = 1'b1;
			r.fail = 1'b1;
		end else if (mode == ENC_FIRST_UP) begin
			r.emit = 1'b1;
			r.res.char_present = 1'b1;
			r.res.char_code = fcn ? to_upper(c) : c;
			r.fcn = 1'b0;
		end else if (mode == ENC_BAR_UP) begin
			if (bar) begin
				r.emit = 1'b1;
				r.res.char_present = 1'b1;
				r.res.char_code = to_upper(c);
				r.bar = 1'b0;
			end else if (c == "|") begin
				r.bar = 1'b1;
			end else begin
				r.emit = 1'b1;
				r.res.char_present = 1'b1;
				r.res.char_code = c;
			end
		end else begin
			r.emit = 1'b1;
			r.res.char_present = 1'b1;
			r.res.char_code = c;
		end
		return r;
	endfunction

	logic        item_v_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  enc_s1;
	logic        last_s1;
	logic [7:0]  special_one_q;
	logic [7:0]  special_two_q;
	pnsd_state_t state_q;
	pnsd_state_t st;
	pnsd_res_t [RES_MAX-1:0] res;
	pnsd_rel_t   rel;
	logic [1:0]  n;
	logic [12:0] acc;
	logic [12:0] shifted;
	logic [3:0]  cnt;
	logic [3:0]  w;
	logic [5:0]  code;
	logic [5:0]  mask6;
	logic [2:0]  mode_keep;
	logic        first;
	logic        load;
	logic        accept;

	assign load       = item_v_s1 && can_load;
	assign item_stall = item_v_s1 && !load;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (accept) begin
			item_v_s1 <= 1'b1;
		end else if (load) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			enc_s1  <= encoding;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			special_one_q <= SPECIAL_ONE_RST;
			special_two_q <= SPECIAL_TWO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPECIAL_ONE: special_one_q <= cfg_data;
				CFG_SPECIAL_TWO: special_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		st        = state_q;
		res       = '0;
		rel       = '0;
		n         = 2'd0;
		acc       = '0;
		shifted   = '0;
		cnt       = '0;
		code      = '0;
		mask6     = '0;
		mode_keep = '0;
		first     = state_q.at_start;
		if (first) begin
			st = STATE_CLEAR;
			st.mode = enc_s1;
		end
		st.at_start = 1'b0;
		w = (st.mode == ENC_MIXED) ? 4'd6 : 4'd5;
		if (st.mode == ENC_UTF8 || st.mode > ENC_BAR_UP) begin
			res[0].char_code = byte_s1;
			res[0].char_present = 1'b1;
			n = 2'd1;
		end else begin
			if (first) begin
				st.strip = byte_s1[7];
				acc = {6'd0, byte_s1[6:0]};
				cnt = 4'd7;
			end else begin
				acc = {st.bit_buffer, byte_s1};
				cnt = {1'b0, st.bit_count} + 4'd8;
			end
			for (int i = 0; i < 2; i++) begin
				if (!st.err && cnt >= w) begin
					cnt = cnt - w;
					shifted = acc >> cnt;
					code = (w == 4'd6) ? shifted[5:0] : {1'b0, shifted[4:0]};
					if (st.held_v) begin
						rel = release_code(st.held, st.mode, st.fcn, st.bar,
							special_one_q, special_two_q);
						st.fcn = rel.fcn;
						st.bar = rel.bar;
						if (rel.emit) begin
							res[n] = rel.res;
							n = n + 2'd1;
						end
						if (rel.fail) begin
							st.err = 1'b1;
							st.held_v = 1'b0;
						end
					end
					if (!st.err) begin
						st.held = code;
						st.held_v = 1'b1;
					end
				end
			end
			if (st.err) begin
				st.bit_buffer = '0;
				st.bit_count = '0;
				st.held_v = 1'b0;
			end else begin
				mask6 = (6'd1 << cnt[2:0]) - 6'd1;
				st.bit_buffer = acc[4:0] & mask6[4:0];
				st.bit_count = cnt[2:0];
			end
			if (last_s1 && !st.err && st.held_v && !st.strip) begin
				rel = release_code(st.held, st.mode, st.fcn, st.bar,
					special_one_q, special_two_q);
				st.fcn = rel.fcn;
				st.bar = rel.bar;
				if (rel.emit) begin
					res[n] = rel.res;
					n = n + 2'd1;
				end
				if (rel.fail) begin
					st.err = 1'b1;
					st.held_v = 1'b0;
				end
			end
		end
		if (last_s1) begin
			if (n == 2'd0) begin
				res[0] = '0;
				n = 2'd1;
			end
			res[n - 2'd1].end_of_string = 1'b1;
			res[n - 2'd1].error = st.err;
			mode_keep = st.mode;
			st = STATE_CLEAR;
			st.mode = mode_keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (load) begin
			state_q <= st;
		end
	end

	assign bundle.load  = load;
	assign bundle.count = n;
	assign bundle.res   = res;

`ifndef SYNTH
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_s1 |=> state_q.at_start)
		else $error("String did not restart after its final item.");
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_s1 |-> bundle.count != 2'd0)
		else $error("Final item of a string produced no result.");
	a_leftover_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_count <= 3'd5)
		else $error("Leftover bit count holds a full code.");
`endif
endmodule

FILE: design/pnsd_outbuf.sv
// ----------------------------------------------------------------------------
// Packed name string decoder output buffer
// Takes the results of one item as a group of up to three and hands them to
// the result channel one per cycle, unless it stalls, from a registered head slot.
// ----------------------------------------------------------------------------
module pnsd_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pnsd_pkg::pnsd_bundle_t bundle,
	output logic                   can_load,
	output logic                   char_valid,
	input  logic                   char_stall,
	output pnsd_pkg::pnsd_res_t    head
);
	import pnsd_pkg::*;

	pnsd_res_t [RES_MAX-1:0] slot_q;
	logic [1:0]              count_q;
	logic                    take;

	assign char_valid = count_q != 2'd0;
	assign take       = char_valid && !char_stall;
	assign can_load   = (count_q == 2'd0) || (count_q == 2'd1 && take);
	assign head       = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (bundle.load) begin
			count_q <= bundle.count;
		end else if (take) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle.load) begin
			slot_q <= bundle.res;
		end else if (take) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				slot_q[i] <= slot_q[i + 1];
			end
		end
	end

`ifndef SYNTH
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.load |-> (count_q == 2'd0 || (count_q == 2'd1 && take)))
		else $error("New results loaded over undelivered results.");
	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !bundle.load |=> count_q == $past(count_q) - 2'd1)
		else $error("Result count did not step down on delivery.");
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.load |=> count_q == $past(bundle.count))
		else $error("Result count does not match the loaded group.");
`endif
endmodule

FILE: test/packed_name_string_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// Packed name string decoder testbench
// Sends whole strings in UTF8 and in the four packed encodings, byte by byte.
// The input and result sides idle at random, except in one calm phase. A
// scoreboard class predicts the characters of each accepted byte and checks
// every result field in order. The special characters are reloaded between
// phases, including 0 and 255.
module packed_name_string_decoder_top_tb;

	import pnsd_pkg::*;

	localparam logic [2:0] ENC_LOWER     = 3'd1;
	localparam logic [4:0] CODE_DOT      = 5'd26;
	localparam logic [4:0] CODE_UNDER    = 5'd27;
	localparam logic [4:0] CODE_DOLLAR   = 5'd28;
	localparam logic [4:0] CODE_BAR      = 5'd29;
	localparam logic [4:0] CODE_BAD_LO   = 5'd30;
	localparam logic [5:0] SIX_UPPER     = 6'd26;
	localparam logic [5:0] SIX_DIGIT     = 6'd52;
	localparam logic [5:0] SIX_SPECIAL   = 6'd62;
	localparam logic [7:0] CH_BAR        = "|";
	localparam int         SETTLE_CYCLES = 8;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         PHASES        = 6;
	localparam int         PHASE_BYTES   = 25;

	class decoded_char_board;
		logic [7:0]  special_one = SPECIAL_ONE_RST;
		logic [7:0]  special_two = SPECIAL_TWO_RST;
		logic [4:0]  spill_bits;
		int unsigned spill_count;
		logic [2:0]  mode;
		logic        strip;
		logic        at_start = 1'b1;
		logic [5:0]  held_code;
		logic        held_ok;
		logic        bar_wait;
		logic        first_pending = 1'b1;
		logic        broken;
		int unsigned step_count;
		pnsd_res_t   pending_chars[$];
		int          mismatches;

		task flag_mismatch(string what, int got, int want);
			$display("mismatch: %s got %0h want %0h", what, got, want);
			mismatches++;
		endtask

		function void clear_string();
			spill_bits = '0;
			spill_count = 0;
			strip = 1'b0;
			held_code = '0;
			held_ok = 1'b0;
			bar_wait = 1'b0;
			first_pending = 1'b1;
			broken = 1'b0;
		endfunction

		function void push_char(logic [7:0] ch, logic present, logic err);
			pnsd_res_t r;
			r.char_code = ch;
			r.char_present = present;
			r.end_of_string = 1'b0;
			r.error = err;
			pending_chars = {pending_chars, r};
			step_count++;
		endfunction

		function logic [7:0] to_upper(logic [7:0] c);
			return (c >= "a" && c <= "z") ? c - 8'd32 : c;
		endfunction

		function void release_code(logic [5:0] code);
			logic [7:0] c;
			logic [4:0] five;
			if (mode == ENC_MIXED) begin
				if (code < SIX_UPPER) c = "a" + code;
				else if (code < SIX_DIGIT) c = "A" + (code - SIX_UPPER);
				else if (code < SIX_SPECIAL) c = "0" + (code - SIX_DIGIT);
				else if (code == SIX_SPECIAL) c = special_one;
				else c = special_two;
				push_char(c, 1'b1, 1'b0);
				return;
			end
			five = code[4:0];
			if (five >= CODE_BAD_LO) begin
				push_char(8'd0, 1'b0, 1'b1);
				broken = 1'b1;
				held_ok = 1'b0;
				return;
			end
			if (five < CODE_DOT) c = "a" + five;
			else if (five == CODE_DOT) c = ".";
			else if (five == CODE_UNDER) c = "_";
			else if (five == CODE_DOLLAR) c = "$";
			else c = CH_BAR;
			if (mode == ENC_FIRST_UP) begin
				if (first_pending) begin
					c = to_upper(c);
					first_pending = 1'b0;
				end
				push_char(c, 1'b1, 1'b0);
			end else if (mode == ENC_BAR_UP) begin
				if (bar_wait) begin
					push_char(to_upper(c), 1'b1, 1'b0);
					bar_wait = 1'b0;
				end else if (c == CH_BAR) begin
					bar_wait = 1'b1;
				end else begin
					push_char(c, 1'b1, 1'b0);
				end
			end else begin
				push_char(c, 1'b1, 1'b0);
			end
		endfunction

		function void take_byte(logic [7:0] b, logic [2:0] enc, logic last);
			logic [12:0] acc;
			logic [12:0] mask;
			int unsigned cnt;
			int unsigned width;
			logic [5:0] code;
			logic first;
			pnsd_res_t r;
			first = at_start;
			step_count = 0;
			if (first) begin
				clear_string();
				mode = enc;
			end
			at_start = 1'b0;
			if (mode == ENC_UTF8 || mode > ENC_BAR_UP) begin
				push_char(b, 1'b1, 1'b0);
			end else begin
				width = (mode == ENC_MIXED) ? 6 : 5;
				mask = (13'd1 << width) - 13'd1;
				if (first) begin
					strip = b[7];
					acc = {6'd0, b[6:0]};
					cnt = 7;
				end else begin
					acc = {spill_bits, b};
					cnt = spill_count + 8;
				end
				if (!broken) begin
					while (cnt >= width) begin
						cnt -= width;
						code = 6'((acc >> cnt) & mask);
						if (held_ok) begin
							release_code(held_code);
							if (broken) break;
						end
						held_code = code;
						held_ok = 1'b1;
					end
				end
				if (broken) begin
					spill_bits = '0;
					spill_count = 0;
					held_ok = 1'b0;
				end else begin
					spill_bits = 5'(acc & ((13'd1 << cnt) - 13'd1));
					spill_count = cnt;
				end
				if (last && !broken && held_ok && !strip) release_code(held_code);
			end
			if (last) begin
				if (step_count == 0) push_char(8'd0, 1'b0, broken);
				r = pending_chars[pending_chars.size() - 1];
				r.end_of_string = 1'b1;
				r.error = broken;
				pending_chars[pending_chars.size() - 1] = r;
				at_start = 1'b1;
				clear_string();
			end
		endfunction

		task match_char(pnsd_res_t got);
			pnsd_res_t want;
			if (pending_chars.size() == 0) begin
				flag_mismatch("result with none expected, char_code", got.char_code, 0);
				return;
			end
			want = pending_chars.pop_front();
			if (got.char_code !== want.char_code)
				flag_mismatch("char_code", got.char_code, want.char_code);
			if (got.char_present !== want.char_present)
				flag_mismatch("char_present", got.char_present, want.char_present);
			if (got.end_of_string !== want.end_of_string)
				flag_mismatch("end_of_string", got.end_of_string, want.end_of_string);
			if (got.error !== want.error)
				flag_mismatch("error", got.error, want.error);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [7:0] data_byte;
	logic [2:0] encoding;
	logic       last_byte;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] char_code;
	logic       char_present;
	logic       end_of_string;
	logic       error;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	decoded_char_board board;
	bit                calm;
	int unsigned       bytes_sent;
	int unsigned       cycles;

	packed_name_string_decoder_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic send_byte(logic [7:0] b, logic [2:0] enc, logic last);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= b;
		encoding <= enc;
		last_byte <= last;
		do @(posedge clk); while (item_stall);
		board.take_byte(b, enc, last);
		bytes_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (board.pending_chars.size() != 0);
	endtask

	task automatic load_specials(logic [7:0] one, logic [7:0] two);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPECIAL_ONE;
		cfg_data <= one;
		@(posedge clk);
		cfg_index <= CFG_SPECIAL_TWO;
		cfg_data <= two;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.special_one = one;
		board.special_two = two;
	endtask

	task automatic send_random_string();
		bit          bits[$];
		logic [2:0]  enc;
		logic [5:0]  code;
		logic [7:0]  b;
		int unsigned pick;
		int unsigned width;
		int unsigned nbytes;
		pick = $urandom_range(0, 9);
		if (pick == 0) enc = ENC_UTF8;
		else if (pick <= 2) enc = ENC_LOWER;
		else if (pick <= 4) enc = ENC_MIXED;
		else if (pick <= 6) enc = ENC_FIRST_UP;
		else enc = ENC_BAR_UP;
		if (enc == ENC_UTF8 || $urandom_range(0, 9) == 0) begin
			nbytes = $urandom_range(1, 5);
			for (int i = 0; i < nbytes; i++)
				send_byte(8'($urandom), enc, i == nbytes - 1);
			return;
		end
		width = (enc == ENC_MIXED) ? 6 : 5;
		bits = {bits, 1'($urandom_range(0, 1))};
		repeat ($urandom_range(1, 9)) begin
			if (width == 6) begin
				code = 6'($urandom_range(0, 63));
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0) code = {1'b0, CODE_BAD_LO} + 6'($urandom_range(0, 1));
				else if (pick < 4 && enc == ENC_BAR_UP) code = {1'b0, CODE_BAR};
				else code = 6'($urandom_range(0, 29));
			end
			for (int k = width - 1; k >= 0; k--) bits = {bits, code[k]};
		end
		while (bits.size() % 8 != 0) bits = {bits, 1'($urandom_range(0, 1))};
		nbytes = bits.size() / 8;
		for (int i = 0; i < nbytes; i++) begin
			for (int k = 0; k < 8; k++) b[7-k] = bits[8*i+k];
			if (i > 0 && $urandom_range(0, 15) == 0) drain_results();
			send_byte(b, enc, i == nbytes - 1);
		end
	endtask

	initial begin : result_side
		int unsigned hold;
		pnsd_res_t   got;
		char_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				char_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				char_stall <= 1'b0;
			end
			do @(posedge clk); while (!(char_valid && !char_stall));
			got.char_code = char_code;
			got.char_present = char_present;
			got.end_of_string = end_of_string;
			got.error = error;
			board.match_char(got);
		end
	end

	initial begin : stimulus
		board = new();
		calm = 1'b0;
		bytes_sent = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		data_byte <= '0;
		encoding <= ENC_UTF8;
		last_byte <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SPECIAL_ONE;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, ENC_UTF8, 1'b0);
		send_byte(8'hFF, ENC_UTF8, 1'b1);
		send_byte(8'h00, ENC_LOWER, 1'b0);
		send_byte(8'hFF, ENC_LOWER, 1'b1);
		send_byte(8'h7F, ENC_LOWER, 1'b0);
		send_byte(8'h00, ENC_LOWER, 1'b0);
		send_byte(8'h55, ENC_LOWER, 1'b1);
		send_byte(8'h80, ENC_LOWER, 1'b1);
		send_byte(8'h7E, ENC_MIXED, 1'b0);
		send_byte(8'hFF, ENC_MIXED, 1'b1);
		send_byte(8'hFE, ENC_MIXED, 1'b0);
		send_byte(8'hFF, ENC_MIXED, 1'b0);
		send_byte(8'hFB, ENC_MIXED, 1'b1);
		send_byte(8'h00, ENC_FIRST_UP, 1'b0);
		send_byte(8'h21, ENC_FIRST_UP, 1'b1);
		send_byte(8'h74, ENC_BAR_UP, 1'b0);
		send_byte(8'h3D, ENC_BAR_UP, 1'b1);
		send_byte(8'h77, ENC_BAR_UP, 1'b0);
		send_byte(8'hA0, ENC_BAR_UP, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 1) load_specials(8'h00, 8'hFF);
			else if (phase == 2) load_specials(8'hFF, 8'h00);
			else if (phase > 2) load_specials(8'($urandom), 8'($urandom));
			calm = (phase == 2);
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES) send_random_string();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending_chars.size() != 0)
			board.flag_mismatch("results never arrived", board.pending_chars.size(), 0);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
